FILE: design/can_id_discovery_table_assert.svh
// Assertion macros used by the identifier table datapath.
`ifndef CAN_ID_DISCOVERY_TABLE_ASSERT_SVH
`define CAN_ID_DISCOVERY_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CIDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cidt: implication check failed");

// Next-cycle implication, checked outside reset.
`define CIDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cidt: next-cycle check failed");

`endif

FILE: design/cidt_pkg.sv
// Types and constants of the CAN identifier discovery table.
package cidt_pkg;

  // Command codes of an input word
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Record status codes
  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EXTENDED = 2'd3;

  localparam int unsigned IDENT_W = 11;
  localparam logic [31:0] HITS_ONE = 32'd1;

  // Input word
  typedef struct packed {
    logic        cmd;
    logic        is_extended;
    logic [28:0] frame_ident;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [7:0]  read_index;
  } cidt_in_t;

  // Result word
  typedef struct packed {
    logic [1:0]  record_status;
    logic        read_ok;
    logic [10:0] entry_ident;
    logic [3:0]  entry_length;
    logic [63:0] entry_payload;
    logic [31:0] entry_hits;
    logic [8:0]  entries_used;
  } cidt_out_t;

  // One table entry as stored
  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [3:0]         length;
    logic [63:0]        payload;
    logic [31:0]        hits;
  } cidt_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       issue;
    logic       rd_issue;
    logic       wr_hit;
    logic       wr_new;
    logic       set_status;
    logic [1:0] status;
    logic       load_out;
  } cidt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_read;
    logic in_ext;
    logic hit;
    logic issue_done;
    logic full;
    logic slot_free;
  } cidt_sts_t;

endpackage

FILE: design/cidt_ctrl.sv
// Controller state machine of the identifier table: sequences search, update, append and read.
module cidt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cidt_pkg::cidt_sts_t sts_i,
  output cidt_pkg::cidt_cmd_t cmd_o
);
  import cidt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_RDREQ = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.in_read) begin
            state_d = S_RDREQ;
          end else if (sts_i.in_ext) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_EXTENDED;
            state_d          = S_LOAD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one entry read per cycle, each compared in the cycle after its read
        cmd_o.issue = !sts_i.issue_done;
        if (sts_i.hit) begin
          cmd_o.wr_hit     = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_UPDATED;
          state_d          = S_LOAD;
        end else if (sts_i.issue_done) begin
          cmd_o.set_status = 1'b1;
          if (sts_i.full) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.wr_new = 1'b1;
            cmd_o.status = ST_INSERTED;
          end
          state_d = S_LOAD;
        end
      end
      S_RDREQ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: design/cidt_dp.sv
// Datapath of the identifier table: entry memory, scan counter, result register.
`include "can_id_discovery_table_assert.svh"
module cidt_dp #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cidt_pkg::cidt_in_t  in_i,
  input  cidt_pkg::cidt_cmd_t cmd_i,
  output cidt_pkg::cidt_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cidt_pkg::cidt_out_t out_o
);
  import cidt_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = (IW > 8) ? IW : 8;
  localparam int unsigned XW = (AW > CW) ? AW : CW;
  localparam int unsigned UW = (CW > 9) ? CW : 9;

  cidt_entry_t mem_q [TABLE_DEPTH];

  cidt_in_t    item_q;
  logic [CW-1:0] used_q, cnt_q;
  logic        pv_q;
  cidt_entry_t rd_data_q;
  logic [IW-1:0] rd_idx_q;
  logic [1:0]  st_q;
  cidt_out_t   out_q;
  logic        out_valid_q;

  logic [AW-1:0] ridx_ext;
  logic [IW-1:0] ridx_addr, rd_addr;
  logic [UW-1:0] used_ext;
  logic          match, rd_ok;
  cidt_entry_t   upd_entry, new_entry;
  cidt_out_t     res;

  assign ridx_ext  = AW'(item_q.read_index);
  assign ridx_addr = ridx_ext[IW-1:0];
  assign rd_addr   = cmd_i.rd_issue ? ridx_addr : cnt_q[IW-1:0];
  assign used_ext  = UW'(used_q);
  assign match     = (rd_data_q.ident == item_q.frame_ident[IDENT_W-1:0]);
  assign rd_ok     = (XW'(item_q.read_index) < XW'(used_q));

  // Status toward the controller
  assign sts_o.in_read    = (in_i.cmd == CMD_READ);
  assign sts_o.in_ext     = in_i.is_extended;
  assign sts_o.hit        = pv_q && match;
  assign sts_o.issue_done = (cnt_q == used_q);
  assign sts_o.full       = (used_q == CW'(TABLE_DEPTH));
  assign sts_o.slot_free  = !out_valid_q || !out_stall_i;

  // Entry images for update on hit and for append
  always_comb begin
    upd_entry         = rd_data_q;
    upd_entry.length  = item_q.frame_length;
    upd_entry.payload = item_q.frame_payload;
    upd_entry.hits    = rd_data_q.hits + HITS_ONE;
    new_entry.ident   = item_q.frame_ident[IDENT_W-1:0];
    new_entry.length  = item_q.frame_length;
    new_entry.payload = item_q.frame_payload;
    new_entry.hits    = HITS_ONE;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue || cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
    if (cmd_i.wr_hit) begin
      mem_q[rd_idx_q] <= upd_entry;
    end else if (cmd_i.wr_new) begin
      mem_q[used_q[IW-1:0]] <= new_entry;
    end
  end

  // Captured word and status code
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_i;
    end
    if (cmd_i.set_status) begin
      st_q <= cmd_i.status;
    end
  end

  // Entry total, scan counter, compare-pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
    end else begin
      if (cmd_i.wr_new) begin
        used_q <= used_q + CW'(1);
      end
      if (cmd_i.capture) begin
        cnt_q <= '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
      pv_q <= cmd_i.issue;
    end
  end

  // Result word
  always_comb begin
    res              = '0;
    res.entries_used = used_ext[8:0];
    if (item_q.cmd == CMD_READ) begin
      if (rd_ok) begin
        res.read_ok       = 1'b1;
        res.entry_ident   = rd_data_q.ident;
        res.entry_length  = rd_data_q.length;
        res.entry_payload = rd_data_q.payload;
        res.entry_hits    = rd_data_q.hits;
      end
    end else begin
      res.record_status = st_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `CIDT_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CW'(TABLE_DEPTH))
  `CIDT_ASSERT_IMP(a_one_write, cmd_i.wr_hit, !cmd_i.wr_new)
  `CIDT_ASSERT_IMP(a_hit_write, cmd_i.wr_hit, pv_q && match)
  `CIDT_ASSERT_NXT(a_used_hold, !cmd_i.wr_new, used_q == $past(used_q))
  `CIDT_ASSERT_IMP(a_no_overwrite, cmd_i.load_out, !out_valid_q || !out_stall_i)

endmodule

FILE: design/can_id_discovery_table.sv
// A record word scans the table, one table entry read per cycle over the entry memory's
// registered read port; a read word reads one entry, an extended frame skips the table.
// Words are taken one at a time: the input stalls until the current word's result is loaded.
// A finished result waits in the output register while the next word is taken.
// Reset empties the table at once through the entry count; entry contents are not cleared.
// Top level of the CAN identifier discovery table.
module can_id_discovery_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cidt_pkg::cidt_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cidt_pkg::cidt_out_t out_o
);
  import cidt_pkg::*;

  cidt_cmd_t cmd;
  cidt_sts_t sts;

  // Sequencer
  cidt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table storage and result path
  cidt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

FILE: tb/can_id_discovery_table_test.sv
// Self-checking testbench for the CAN identifier discovery table.
module can_id_discovery_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cidt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_WORDS = 630;

  typedef struct {
    cidt_in_t word;
    bit       drain_first;
  } pending_word_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  cidt_in_t  in_word = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  cidt_out_t out_o;

  pending_word_t pending_words[$];
  cidt_out_t     expected_results[$];
  int            errors = 0;
  int            quiet_cycles = 0;

  // Predicted table contents
  logic [10:0] known_ident[TABLE_DEPTH];
  logic [3:0]  known_length[TABLE_DEPTH];
  logic [63:0] known_payload[TABLE_DEPTH];
  logic [31:0] known_hits[TABLE_DEPTH];
  int          known_total = 0;

  // Identifiers handed out by the stimulus so far
  bit          id_seen[2048];
  logic [10:0] id_pool[$];

  can_id_discovery_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_i       (in_word),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_o      (out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one accepted word to the predicted table and return its result
  function automatic cidt_out_t predict_table_result(cidt_in_t w);
    cidt_out_t   r;
    logic [10:0] sid;
    int          slot;
    int          k;
    r = '0;
    if (w.cmd == CMD_RECORD) begin
      if (w.is_extended) begin
        r.record_status = ST_EXTENDED;
      end else begin
        sid = w.frame_ident[10:0];
        slot = -1;
        for (k = 0; k < known_total; k++) begin
          if (slot < 0 && known_ident[k] == sid) slot = k;
        end
        if (slot >= 0) begin
          known_length[slot]  = w.frame_length;
          known_payload[slot] = w.frame_payload;
          known_hits[slot]    = known_hits[slot] + 32'd1;
          r.record_status     = ST_UPDATED;
        end else if (known_total < TABLE_DEPTH) begin
          known_ident[known_total]   = sid;
          known_length[known_total]  = w.frame_length;
          known_payload[known_total] = w.frame_payload;
          known_hits[known_total]    = 32'd1;
          known_total++;
          r.record_status = ST_INSERTED;
        end else begin
          r.record_status = ST_FULL;
        end
      end
    end else if (int'(w.read_index) < known_total) begin
      r.read_ok       = 1'b1;
      r.entry_ident   = known_ident[w.read_index];
      r.entry_length  = known_length[w.read_index];
      r.entry_payload = known_payload[w.read_index];
      r.entry_hits    = known_hits[w.read_index];
    end
    r.entries_used = 9'(known_total);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  function automatic cidt_in_t make_record(logic ext, logic [28:0] ident, logic [3:0] len,
                                           logic [63:0] payload);
    cidt_in_t w;
    w = '0;
    w.cmd           = CMD_RECORD;
    w.is_extended   = ext;
    w.frame_ident   = ident;
    w.frame_length  = len;
    w.frame_payload = payload;
    return w;
  endfunction

  function automatic cidt_in_t make_read(logic [7:0] idx);
    cidt_in_t w;
    w = '0;
    w.cmd        = CMD_READ;
    w.read_index = idx;
    return w;
  endfunction

  function automatic void queue_word(cidt_in_t w, bit drain_first);
    pending_word_t p;
    p.word        = w;
    p.drain_first = drain_first;
    pending_words.push_back(p);
  endfunction

  // A standard identifier not handed out before
  function automatic logic [10:0] fresh_ident();
    logic [10:0] sid;
    do sid = 11'($urandom_range(0, 2047)); while (id_seen[sid]);
    id_seen[sid] = 1'b1;
    id_pool.push_back(sid);
    return sid;
  endfunction

  function automatic logic [10:0] known_ident_pick();
    return id_pool[$urandom_range(0, id_pool.size() - 1)];
  endfunction

  // Driver: bursts of words with random gaps, optional drain before a word
  always @(posedge clk_i) begin : word_driver
    int gap_left;
    int burst_left;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_results.push_back(predict_table_result(in_word));
        void'(pending_words.pop_front());
      end
      if (!(in_valid && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() == 0 ||
                     (pending_words[0].drain_first && expected_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_word  <= pending_words[0].word;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 4);
          end
        end
      end
    end
  end

  // Monitor: check result words, stall in changing modes
  always @(posedge clk_i) begin : result_monitor
    cidt_out_t   want;
    stall_mode_e stall_mode;
    int          stall_phase;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_mode  = STALL_NONE;
      stall_phase = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, out_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("record_status", 64'(want.record_status), 64'(out_o.record_status));
          check_field("read_ok", 64'(want.read_ok), 64'(out_o.read_ok));
          check_field("entry_ident", 64'(want.entry_ident), 64'(out_o.entry_ident));
          check_field("entry_length", 64'(want.entry_length), 64'(out_o.entry_length));
          check_field("entry_payload", want.entry_payload, out_o.entry_payload);
          check_field("entry_hits", 64'(want.entry_hits), 64'(out_o.entry_hits));
          check_field("entries_used", 64'(want.entries_used), 64'(out_o.entries_used));
        end
      end
      if (stall_phase == 0) begin
        stall_mode  = stall_mode_e'($urandom_range(0, 3));
        stall_phase = $urandom_range(64, 400);
      end else begin
        stall_phase--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_n) quiet_cycles <= 0;
    else if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : stimulus
    cidt_in_t    w;
    logic [10:0] sid;
    int          pick;
    int          i;

    // Directed: empty table, extremes, ignored identifier bits, extended frames
    queue_word(make_read(8'd0), 1'b0);
    queue_word(make_record(1'b1, '1, 4'hF, '1), 1'b0);
    queue_word(make_record(1'b0, 29'h0, 4'h0, 64'h0), 1'b0);
    queue_word(make_record(1'b0, 29'h1FFF_FFFF, 4'hF, '1), 1'b0);
    queue_word(make_record(1'b0, 29'h1FFF_F800, 4'h9, 64'h0123_4567_89AB_CDEF), 1'b0);
    queue_word(make_record(1'b1, 29'h0, 4'h3, 64'hFFFF_0000_FFFF_0000), 1'b0);
    queue_word(make_read(8'd0), 1'b1);
    queue_word(make_read(8'd1), 1'b0);
    queue_word(make_read(8'd2), 1'b0);
    queue_word(make_read(8'hFF), 1'b0);
    // read word with every frame field set, all of them ignored
    w = make_read(8'd1);
    w.is_extended   = 1'b1;
    w.frame_ident   = '1;
    w.frame_length  = '1;
    w.frame_payload = '1;
    queue_word(w, 1'b0);
    queue_word(make_record(1'b0, 29'h0000_07FF, 4'h1, 64'h8000_0000_0000_0001), 1'b0);
    queue_word(make_read(8'd1), 1'b0);
    id_seen[11'h000] = 1'b1;
    id_seen[11'h7FF] = 1'b1;
    id_pool.push_back(11'h000);
    id_pool.push_back(11'h7FF);

    // Random: hit-heavy start, then fill the table, then run it full
    for (i = 0; i < RANDOM_WORDS; i++) begin
      pick            = $urandom_range(0, 99);
      w.cmd           = CMD_RECORD;
      w.is_extended   = 1'b0;
      w.frame_ident   = 29'($urandom());
      w.frame_length  = 4'($urandom());
      w.frame_payload = {$urandom(), $urandom()};
      w.read_index    = 8'($urandom());
      if (i < 200) begin
        if (pick < 65) begin
          sid = ($urandom_range(0, 99) < 60) ? known_ident_pick() : fresh_ident();
          w.frame_ident[10:0] = sid;
        end else if (pick < 90) begin
          w.cmd        = CMD_READ;
          w.read_index = 8'($urandom_range(0, (id_pool.size() < 250) ? id_pool.size() + 4 : 255));
        end else begin
          w.is_extended = 1'b1;
        end
      end else if (i < 460) begin
        if (pick < 90) begin
          sid = ($urandom_range(0, 99) < 95) ? fresh_ident() : known_ident_pick();
          w.frame_ident[10:0] = sid;
        end else if (pick < 97) begin
          w.cmd = CMD_READ;
        end else begin
          w.is_extended = 1'b1;
        end
      end else begin
        if (pick < 55) begin
          sid = ($urandom_range(0, 1) == 0) ? fresh_ident() : known_ident_pick();
          w.frame_ident[10:0] = sid;
        end else if (pick < 90) begin
          w.cmd = CMD_READ;
        end else begin
          w.is_extended = 1'b1;
        end
      end
      queue_word(w, (i % 150) == 75);
    end

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk_i);
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("can_id_discovery_table_test: done, errors");
        $finish;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("can_id_discovery_table_test: done, clean");
    end else begin
      $display("can_id_discovery_table_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/cidt_pkg.sv
design/cidt_ctrl.sv
design/cidt_dp.sv
design/can_id_discovery_table.sv
tb/can_id_discovery_table_test.sv
